@@ rtl/xcp_checksum_engine_assert.svh @@
// ----------------------------------------------------------------------------
// xcp_checksum_engine assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef XCP_CHECKSUM_ENGINE_ASSERT_SVH
`define XCP_CHECKSUM_ENGINE_ASSERT_SVH

// same-cycle implication
`define XCP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xcp checksum engine: assertion failed");

// next-cycle implication
`define XCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xcp checksum engine: assertion failed");

`endif

@@ rtl/xcp_pkg.sv @@
// ----------------------------------------------------------------------------
// xcp_pkg
// Checksum kind codes, running state type and byte-wide CRC functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcp_pkg;

    localparam logic [3:0] KIND_ADD11 = 4'd0;
    localparam logic [3:0] KIND_ADD12 = 4'd1;
    localparam logic [3:0] KIND_ADD14 = 4'd2;
    localparam logic [3:0] KIND_ADD22 = 4'd3;
    localparam logic [3:0] KIND_ADD24 = 4'd4;
    localparam logic [3:0] KIND_ADD44 = 4'd5;
    localparam logic [3:0] KIND_CRC16 = 4'd6;
    localparam logic [3:0] KIND_CCITT = 4'd7;
    localparam logic [3:0] KIND_CRC32 = 4'd8;

    localparam logic [15:0] CRC16_POLY_REF = 16'hA001;
    localparam logic [15:0] CCITT_POLY     = 16'h1021;
    localparam logic [31:0] CRC32_POLY_REF = 32'hEDB8_8320;

    typedef struct packed {
        logic [31:0] running_sum;
        logic [23:0] element_assembly;
        logic [1:0]  byte_position;
    } state_t;

    function automatic logic [31:0] start_value(input logic [3:0] kind);
        logic [31:0] v;
        case (kind)
            KIND_CCITT: v = 32'h0000_FFFF;
            KIND_CRC32: v = 32'hFFFF_FFFF;
            default:    v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic state_t start_state(input logic [3:0] kind);
        state_t s;
        s.running_sum      = start_value(kind);
        s.element_assembly = 24'h0;
        s.byte_position    = 2'd0;
        return s;
    endfunction

    // byte index of the final byte of one element
    function automatic logic [1:0] elem_last_pos(input logic [3:0] kind);
        logic [1:0] p;
        case (kind)
            KIND_ADD22, KIND_ADD24: p = 2'd1;
            KIND_ADD44:             p = 2'd3;
            default:                p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic [31:0] sum_mask(input logic [3:0] kind);
        logic [31:0] m;
        case (kind)
            KIND_ADD11:             m = 32'h0000_00FF;
            KIND_ADD12, KIND_ADD22: m = 32'h0000_FFFF;
            default:                m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] c_in,
                                                   input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY_REF) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] ccitt_byte(input logic [15:0] c_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CCITT_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in,
                                               input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC32_POLY_REF) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/xcp_sum_update.sv @@
// ----------------------------------------------------------------------------
// xcp_sum_update
// One-byte update of the running checksum state and the finished value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcp_sum_update (
    input  logic [3:0]    kind,
    input  xcp_pkg::state_t state,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output xcp_pkg::state_t state_next,
    output logic [31:0]   result
);
    import xcp_pkg::*;

    state_t      upd;
    logic [31:0] elem;
    logic [1:0]  pos;

    always_comb
    begin
        upd  = state;
        pos  = state.byte_position;
        elem = 32'h0;
        case (pos)
            2'd0:    elem = {24'h0, data_byte};
            2'd1:    elem = {16'h0, data_byte, state.element_assembly[7:0]};
            2'd2:    elem = {8'h0, data_byte, state.element_assembly[15:0]};
            default: elem = {data_byte, state.element_assembly};
        endcase

        case (kind)
            KIND_ADD11, KIND_ADD12, KIND_ADD14, KIND_ADD22, KIND_ADD24, KIND_ADD44:
            begin
                if (pos != elem_last_pos(kind))
                begin
                    upd.element_assembly = elem[23:0];
                    upd.byte_position    = pos + 2'd1;
                end
                else
                begin
                    upd.running_sum      = (state.running_sum + elem) & sum_mask(kind);
                    upd.element_assembly = 24'h0;
                    upd.byte_position    = 2'd0;
                end
            end
            KIND_CRC16:
                upd.running_sum = {16'h0, crc16_arc_byte(state.running_sum[15:0], data_byte)};
            KIND_CCITT:
                upd.running_sum = {16'h0, ccitt_byte(state.running_sum[15:0], data_byte)};
            KIND_CRC32:
                upd.running_sum = crc32_byte(state.running_sum, data_byte);
            default:
                upd = state;
        endcase

        case (kind)
            KIND_ADD11, KIND_ADD12, KIND_ADD14, KIND_ADD22, KIND_ADD24, KIND_ADD44:
                result = upd.running_sum & sum_mask(kind);
            KIND_CRC16, KIND_CCITT:
                result = {16'h0, upd.running_sum[15:0]};
            KIND_CRC32:
                result = ~upd.running_sum;
            default:
                result = 32'h0;
        endcase

        state_next = last_byte ? start_state(kind) : upd;
    end

endmodule

@@ rtl/xcp_checksum_engine.sv @@
// A byte is registered into stage 1 on accept; when stage 1 advances, its
//   state update and, on the last byte, the checksum are written into the
//   state and result registers (a last byte waits while a result is unread).
// One byte per cycle is taken while no last byte waits on an unread result.
// A finished checksum waits in the result register while bytes keep flowing.
// Reset (rst_n low, async): kind 0 (add11), state cleared, both stages empty.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcp_checksum_engine
// Additive and CRC checksum over a byte stream, emitted on the last byte.
// ----------------------------------------------------------------------------

module xcp_checksum_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] checksum_value
);
    import xcp_pkg::*;

    logic [3:0]  kind_reg;
    state_t      state_reg;
    state_t      state_next;
    state_t      upd_state;
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_data_reg;
    logic [31:0] upd_result;
    logic        s1_adv;
    logic        out_load;
    logic        cfg_write;
    logic        multi_byte_kind;

    xcp_sum_update u_update (
        .kind       (kind_reg),
        .state      (state_reg),
        .data_byte  (s1_byte_reg),
        .last_byte  (s1_last_reg),
        .state_next (upd_state),
        .result     (upd_result)
    );

    assign s1_adv    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign out_load  = s1_adv && s1_last_reg;
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign cfg_ready = !s1_valid_reg;
    assign cfg_write = cfg_valid && cfg_ready;

    assign multi_byte_kind = (kind_reg == KIND_ADD22) || (kind_reg == KIND_ADD24) ||
                             (kind_reg == KIND_ADD44);

    always_comb
    begin
        if (cfg_write)
            state_next = start_state(cfg_data);
        else if (s1_adv)
            state_next = upd_state;
        else
            state_next = state_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_ADD11;
            state_reg     <= start_state(KIND_ADD11);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                kind_reg <= cfg_data;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_ready)
                s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (out_load)
            out_data_reg <= upd_result;
    end

    assign out_valid      = out_valid_reg;
    assign checksum_value = out_data_reg;

`include "xcp_checksum_engine_assert.svh"

    `XCP_ASSERT_NEXT(a_last_gives_result, out_load, out_valid_reg)
    `XCP_ASSERT_IMPL(a_stall_only_when_full, !in_ready, s1_valid_reg)
    `XCP_ASSERT_NEXT(a_restart_after_last, out_load && !cfg_write, state_reg.byte_position == 2'd0)
    `XCP_ASSERT_IMPL(a_pos_single_byte_kinds, !multi_byte_kind, state_reg.byte_position == 2'd0)

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for xcp_checksum_engine. A short table of directed
// requests walks every checksum kind, the unused codes, partial elements and
// a kind rewrite in the middle of a block. Random phases follow: random kind,
// random block lengths, random idling on both sides, a long receiver
// hold-off and a sender pause. Every finished checksum is compared with the
// table value where one is given, else with an in-bench predictor.
// ----------------------------------------------------------------------------

module tb_top;
    import xcp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES  = 1400;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_MAX    = 10;
    localparam int PLAN_ROWS     = 36;

    localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
    localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

    typedef enum logic { ROW_CFG, ROW_BYTE } row_op_e;

    typedef struct packed {
        row_op_e     op;
        logic [7:0]  value;
        logic        last;
        logic        known;
        logic [31:0] sum;
    } plan_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data  = 4'h0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] checksum_value;

    // predictor state
    logic [3:0]  kind_sel;
    logic [31:0] sum_acc;
    logic [23:0] elem_acc;
    int          elem_pos;
    logic [31:0] checksum_q [$];

    logic [31:0] due_sum;
    int          fault_count  = 0;
    int          bytes_sent   = 0;
    int          cycle_count  = 0;
    bit          calm         = 1'b0;
    bit          hold_pending = 1'b0;

    plan_row_t   plan [PLAN_ROWS];

    xcp_checksum_engine u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .checksum_value (checksum_value)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic logic [31:0] kind_seed(input logic [3:0] k);
        if (k == KIND_CCITT)
            return 32'h0000_FFFF;
        if (k == KIND_CRC32)
            return 32'hFFFF_FFFF;
        return 32'h0;
    endfunction

    task automatic restart_sum();
        sum_acc  = kind_seed(kind_sel);
        elem_acc = 24'h0;
        elem_pos = 0;
    endtask

    task automatic fold_byte(input logic [7:0] b, input logic l,
                             output logic done, output logic [31:0] sum_out);
        logic [31:0] word;
        logic [31:0] mask;
        logic [15:0] c16;
        int          width;
        done    = 1'b0;
        sum_out = 32'h0;
        case (kind_sel)
            KIND_ADD11, KIND_ADD12, KIND_ADD14, KIND_ADD22, KIND_ADD24, KIND_ADD44:
            begin
                if (kind_sel == KIND_ADD44)
                    width = 4;
                else if (kind_sel == KIND_ADD22 || kind_sel == KIND_ADD24)
                    width = 2;
                else
                    width = 1;
                if (kind_sel == KIND_ADD11)
                    mask = 32'h0000_00FF;
                else if (kind_sel == KIND_ADD12 || kind_sel == KIND_ADD22)
                    mask = 32'h0000_FFFF;
                else
                    mask = 32'hFFFF_FFFF;
                word = {8'h00, elem_acc} | ({24'h0, b} << (8 * elem_pos));
                if (elem_pos + 1 < width)
                begin
                    elem_acc = word[23:0];
                    elem_pos++;
                end
                else
                begin
                    sum_acc  = (sum_acc + word) & mask;
                    elem_acc = 24'h0;
                    elem_pos = 0;
                end
            end
            KIND_CRC16:
            begin
                c16 = sum_acc[15:0] ^ {8'h00, b};
                repeat (8)
                    c16 = c16[0] ? ((c16 >> 1) ^ CRC16_POLY_REF) : (c16 >> 1);
                sum_acc = {16'h0, c16};
            end
            KIND_CCITT:
            begin
                c16 = sum_acc[15:0] ^ {b, 8'h00};
                repeat (8)
                    c16 = c16[15] ? ({c16[14:0], 1'b0} ^ CCITT_POLY) : {c16[14:0], 1'b0};
                sum_acc = {16'h0, c16};
            end
            KIND_CRC32:
            begin
                word = sum_acc ^ {24'h0, b};
                repeat (8)
                    word = word[0] ? ((word >> 1) ^ CRC32_POLY_REF) : (word >> 1);
                sum_acc = word;
            end
            default:
            begin
            end
        endcase
        if (l)
        begin
            done = 1'b1;
            if (kind_sel == KIND_CRC32)
                sum_out = ~sum_acc;
            else if (kind_sel > KIND_CRC32)
                sum_out = 32'h0;
            else
                sum_out = sum_acc;
            restart_sum();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l,
                             input logic known, input logic [31:0] known_sum);
        logic        done;
        logic [31:0] sum_out;
        while (!calm && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fold_byte(b, l, done, sum_out);
        if (done)
            checksum_q.insert(checksum_q.size(), known ? known_sum : sum_out);
        bytes_sent++;
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (checksum_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_kind(input logic [3:0] k);
        wait_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        kind_sel = k;
        restart_sum();
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (checksum_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("unexpected checksum: got %08h", checksum_value);
            end
            else
            begin
                due_sum = checksum_q.pop_front();
                if (checksum_value !== due_sum)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("checksum mismatch: expected %08h got %08h",
                                 due_sum, checksum_value);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int         phase;
        int         blocks;
        int         len;
        int         random_start;
        logic [3:0] k;

        plan = '{
            '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 32'h0000_00FF},
            '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 32'h0000_0000},
            '{ROW_CFG,  {4'h0, KIND_ADD14}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 32'h0000_01FE},
            '{ROW_CFG,  {4'h0, KIND_ADD44}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h02, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h03, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h04, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h05, 1'b1, 1'b1, 32'h0403_0201},
            '{ROW_CFG,  {4'h0, KIND_ADD22}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 32'h0000_FFFE},
            '{ROW_CFG,  {4'h0, KIND_ADD24}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h34, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h12, 1'b1, 1'b1, 32'h0000_1234},
            '{ROW_CFG,  {4'h0, KIND_ADD12}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h80, 1'b1, 1'b0, 32'h0},
            '{ROW_CFG,  {4'h0, KIND_CRC16}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 32'h0000_0000},
            '{ROW_CFG,  {4'h0, KIND_CCITT}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 32'h0},
            '{ROW_CFG,  {4'h0, KIND_CRC32}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h5A, 1'b0, 1'b0, 32'h0},
            // rewrite mid-block drops the byte above
            '{ROW_CFG,  {4'h0, KIND_CRC32}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 32'h0},
            '{ROW_CFG,  {4'h0, KIND_UNUSED_HI}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'hAB, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'hCD, 1'b1, 1'b1, 32'h0000_0000},
            '{ROW_CFG,  {4'h0, KIND_UNUSED_LO}, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 32'h0000_0000},
            '{ROW_CFG,  {4'h0, KIND_ADD11}, 1'b0, 1'b0, 32'h0}
        };

        kind_sel = KIND_ADD11;
        restart_sum();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].op == ROW_CFG)
                write_kind(plan[i].value[3:0]);
            else
                send_byte(plan[i].value, plan[i].last, plan[i].known, plan[i].sum);
        end

        phase        = 0;
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            if (phase == 0)
                k = KIND_ADD11;
            else if (phase == 1)
                k = KIND_UNUSED_HI;
            else if (phase == 2)
                k = KIND_CRC32;
            else if ($urandom_range(9) == 0)
                k = 4'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
            else
                k = 4'($urandom_range(KIND_CRC32, KIND_ADD11));
            write_kind(k);
            calm   = (phase >= 6 && phase <= 8);
            blocks = $urandom_range(12, 3);
            if (phase == 4)
            begin
                // short blocks pile up results behind the held receiver
                hold_pending = 1'b1;
                blocks       = 40;
            end
            for (int blk = 0; blk < blocks; blk++)
            begin
                if (phase == 4)
                    len = $urandom_range(2, 1);
                else if ($urandom_range(9) < 8)
                    len = $urandom_range(12, 1);
                else
                    len = $urandom_range(48, 13);
                for (int j = 0; j < len; j++)
                    send_byte(8'($urandom_range(255)), j == len - 1, 1'b0, 32'h0);
                if (phase == 5 && blk == blocks / 2)
                    wait_results();
            end
            if ($urandom_range(6) == 0)
            begin
                len = $urandom_range(5, 1);
                for (int j = 0; j < len; j++)
                    send_byte(8'($urandom_range(255)), 1'b0, 1'b0, 32'h0);
            end
            phase++;
        end
        calm = 1'b0;

        wait_results();
        repeat (SETTLE_CYCLES * 4)
            @(posedge clk);
        if (fault_count == 0 && checksum_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
